@@ rtl/sle_pkg.sv @@
// Shared types, constants and the scancode table of the scancode line editor.
// Used by every module of the block but the RAM; depends on nothing.
`timescale 1ns / 1ps

package sle_pkg;

    // Line store geometry.
    localparam int LINE_DEPTH = 64;
    localparam int LEN_W      = $clog2(LINE_DEPTH);

    // Depth of the command queue between the front and the back.
    localparam int CMD_DEPTH = 4;
    localparam int CPTR_W    = $clog2(CMD_DEPTH);
    localparam int CCNT_W    = $clog2(CMD_DEPTH + 1);

    // Scancodes with a meaning of their own.
    localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
    localparam logic [7:0] CODE_ENTER     = 8'h1C;
    localparam logic [7:0] CODE_CAPS      = 8'h3A;
    localparam logic [7:0] CODE_TOP       = 8'd57;

    localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
    localparam logic [6:0] CASE_OFFSET  = 7'd32;

    // Result kinds as seen on the output ports.
    typedef enum logic [2:0] {
        KIND_ECHO      = 3'd0,
        KIND_BACK      = 3'd1,
        KIND_LINE_CHAR = 3'd2,
        KIND_LINE_END  = 3'd3,
        KIND_DROPPED   = 3'd4
    } kind_t;

    // Commands from the front to the back.
    typedef enum logic [1:0] {
        CMD_ECHO,
        CMD_BACK,
        CMD_DROP,
        CMD_ENTER
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [6:0]       ch;
        logic [LEN_W-1:0] len;
    } cmd_t;

    // Write request from the front into the line store.
    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] addr;
        logic [6:0]       data;
    } line_wr_t;

    // Lower-case character of each set-1 make code from 0 to 57.
    function automatic logic [6:0] key_char(input logic [5:0] code);
        logic [6:0] c;
        case (code)
            6'd2:  c = 7'h31;
            6'd3:  c = 7'h32;
            6'd4:  c = 7'h33;
            6'd5:  c = 7'h34;
            6'd6:  c = 7'h35;
            6'd7:  c = 7'h36;
            6'd8:  c = 7'h37;
            6'd9:  c = 7'h38;
            6'd10: c = 7'h39;
            6'd11: c = 7'h30;
            6'd12: c = 7'h2D;
            6'd13: c = 7'h3D;
            6'd16: c = 7'h71;
            6'd17: c = 7'h77;
            6'd18: c = 7'h65;
            6'd19: c = 7'h72;
            6'd20: c = 7'h74;
            6'd21: c = 7'h79;
            6'd22: c = 7'h75;
            6'd23: c = 7'h69;
            6'd24: c = 7'h6F;
            6'd25: c = 7'h70;
            6'd26: c = 7'h5B;
            6'd27: c = 7'h5D;
            6'd30: c = 7'h61;
            6'd31: c = 7'h73;
            6'd32: c = 7'h64;
            6'd33: c = 7'h66;
            6'd34: c = 7'h67;
            6'd35: c = 7'h68;
            6'd36: c = 7'h6A;
            6'd37: c = 7'h6B;
            6'd38: c = 7'h6C;
            6'd39: c = 7'h3B;
            6'd40: c = 7'h27;
            6'd41: c = 7'h60;
            6'd43: c = 7'h5C;
            6'd44: c = 7'h7A;
            6'd45: c = 7'h78;
            6'd46: c = 7'h63;
            6'd47: c = 7'h76;
            6'd48: c = 7'h62;
            6'd49: c = 7'h6E;
            6'd50: c = 7'h6D;
            6'd51: c = 7'h2C;
            6'd52: c = 7'h2E;
            6'd53: c = 7'h2F;
            6'd57: c = 7'h20;
            default: c = CHAR_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/sle_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sle_front.sv @@
// Front end: accepts scancodes, tracks caps lock and the line length,
// writes typed characters into the line store and queues commands for the back.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       scancode,
    input  logic             push,
    output logic             full,
    input  logic             cmd_full,
    output logic             cmd_push,
    output sle_pkg::cmd_t    cmd,
    output sle_pkg::line_wr_t line_wr,
    input  logic             drain_done
);
    import sle_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_DEPTH - 1);

    logic             caps_reg, caps_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             pending_reg, pending_next;
    logic             accept;
    logic [6:0]       mapped;
    logic [6:0]       ch;

    // Hold off input while the queue is full or a line is being drained.
    assign full   = cmd_full || pending_reg;
    assign accept = push && !full;

    // Map the code and apply the case flag to letters.
    always_comb
    begin
        mapped = key_char(scancode[5:0]);
        if (caps_reg && mapped >= CHAR_LOWER_A && mapped <= CHAR_LOWER_Z)
        begin
            ch = mapped - CASE_OFFSET;
        end
        else
        begin
            ch = mapped;
        end
    end

    // Classify the transfer and decide the command and state update.
    always_comb
    begin
        caps_next    = caps_reg;
        len_next     = len_reg;
        pending_next = pending_reg;
        cmd_push     = 1'b0;
        cmd.op       = CMD_ECHO;
        cmd.ch       = ch;
        cmd.len      = len_reg;
        line_wr.en   = 1'b0;
        line_wr.addr = len_reg;
        line_wr.data = ch;
        if (drain_done)
        begin
            pending_next = 1'b0;
        end
        if (accept)
        begin
            if (scancode == CODE_CAPS)
            begin
                caps_next = !caps_reg;
            end
            else if (scancode > CODE_TOP)
            begin
                // Releases and unknown codes leave everything as it is.
            end
            else if (scancode == CODE_BACKSPACE)
            begin
                if (len_reg != '0)
                begin
                    len_next = len_reg - 1'b1;
                    cmd_push = 1'b1;
                    cmd.op   = CMD_BACK;
                end
            end
            else if (scancode == CODE_ENTER)
            begin
                len_next     = '0;
                pending_next = 1'b1;
                cmd_push     = 1'b1;
                cmd.op       = CMD_ENTER;
            end
            else if (len_reg >= LEN_MAX)
            begin
                cmd_push = 1'b1;
                cmd.op   = CMD_DROP;
            end
            else
            begin
                line_wr.en = 1'b1;
                len_next   = len_reg + 1'b1;
                cmd_push   = 1'b1;
                cmd.op     = CMD_ECHO;
            end
        end
    end

    // Front state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_reg    <= 1'b0;
            len_reg     <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            caps_reg    <= caps_next;
            len_reg     <= len_next;
            pending_reg <= pending_next;
        end
    end

endmodule

@@ rtl/sle_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sle_pkg::cmd_t wr_cmd,
    output logic          cmd_full,
    output logic          cmd_empty,
    input  logic          rd_en,
    output sle_pkg::cmd_t rd_cmd
);
    import sle_pkg::*;

    localparam logic [CPTR_W-1:0] PTR_LAST = CPTR_W'(CMD_DEPTH - 1);
    localparam logic [CCNT_W-1:0] CNT_FULL = CCNT_W'(CMD_DEPTH);

    cmd_t              slot_reg [CMD_DEPTH];
    logic [CPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CCNT_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign cmd_full  = (count_reg == CNT_FULL);
    assign cmd_empty = (count_reg == '0);
    assign do_wr     = wr_en && !cmd_full;
    assign do_rd     = rd_en && !cmd_empty;
    assign rd_cmd    = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue slots carry payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

@@ rtl/sle_back.sv @@
// Back end: carries out queued commands, drains the line store on enter
// and holds the result register seen on the output ports.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_empty,
    input  sle_pkg::cmd_t             cmd,
    output logic                      cmd_pop,
    output logic                      rd_en,
    output logic [sle_pkg::LEN_W-1:0] rd_addr,
    input  logic [6:0]                rd_data,
    output logic                      drain_done,
    output sle_pkg::kind_t            kind,
    output logic [6:0]                character,
    output logic                      last,
    output logic                      empty,
    input  logic                      pop
);
    import sle_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN_RD,
        ST_DRAIN_DATA
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    kind_t            kind_reg, kind_next;
    logic [6:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic             slot_free;
    logic             load;

    // The result register can take a new result when it is empty or being popped.
    assign slot_free = !valid_reg || pop;

    // Command sequencing and result selection.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        load       = 1'b0;
        cmd_pop    = 1'b0;
        rd_en      = 1'b0;
        drain_done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && slot_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        CMD_ECHO:
                        begin
                            load      = 1'b1;
                            kind_next = KIND_ECHO;
                            char_next = cmd.ch;
                            last_next = 1'b1;
                        end
                        CMD_BACK:
                        begin
                            load      = 1'b1;
                            kind_next = KIND_BACK;
                            char_next = '0;
                            last_next = 1'b1;
                        end
                        CMD_DROP:
                        begin
                            load      = 1'b1;
                            kind_next = KIND_DROPPED;
                            char_next = '0;
                            last_next = 1'b1;
                        end
                        CMD_ENTER:
                        begin
                            idx_next   = '0;
                            cnt_next   = cmd.len;
                            state_next = ST_DRAIN_RD;
                        end
                        default:
                        begin
                            cmd_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_DRAIN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    // Whole line sent: close it with the line-end result.
                    if (slot_free)
                    begin
                        load       = 1'b1;
                        kind_next  = KIND_LINE_END;
                        char_next  = '0;
                        last_next  = 1'b1;
                        drain_done = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_DRAIN_DATA;
                end
            end
            ST_DRAIN_DATA:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    kind_next  = KIND_LINE_CHAR;
                    char_next  = rd_data;
                    last_next  = 1'b0;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    assign rd_addr   = idx_reg;
    assign empty     = !valid_reg;
    assign kind      = kind_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            kind_reg  <= KIND_ECHO;
            char_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            kind_reg  <= kind_next;
            char_reg  <= char_next;
            last_reg  <= last_next;
        end
    end

endmodule

@@ rtl/scancode_line_editor_top.sv @@
// Echo, backspace and drop results pass the command queue into the result register.
// Throughput: one scancode per cycle while the four-entry command queue has room.
// Enter reads each stored character from the line-store read port and sends it,
// then the line end; input is held off until that line end is in the result register.
// Reset is asynchronous, active low: caps flag, line length and queues clear at once;
// the line store has no reset and needs no clearing pass.
`timescale 1ns / 1ps

module scancode_line_editor_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     scancode,
    input  logic           push,
    output logic           full,
    output sle_pkg::kind_t kind,
    output logic [6:0]     character,
    output logic           last,
    output logic           empty,
    input  logic           pop
);
    import sle_pkg::*;

    cmd_t             front_cmd;
    cmd_t             back_cmd;
    logic             cmd_push;
    logic             cmd_pop;
    logic             cmd_full;
    logic             cmd_empty;
    line_wr_t         line_wr;
    logic             rd_en;
    logic [LEN_W-1:0] rd_addr;
    logic [6:0]       rd_data;
    logic             drain_done;

    // Front end: classification and line bookkeeping.
    sle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scancode   (scancode),
        .push       (push),
        .full       (full),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd        (front_cmd),
        .line_wr    (line_wr),
        .drain_done (drain_done)
    );

    // Command queue.
    sle_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_push),
        .wr_cmd    (front_cmd),
        .cmd_full  (cmd_full),
        .cmd_empty (cmd_empty),
        .rd_en     (cmd_pop),
        .rd_cmd    (back_cmd)
    );

    // Line store.
    sle_ram #(
        .WIDTH (7),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr.en),
        .wr_addr (line_wr.addr),
        .wr_data (line_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Back end: result generation.
    sle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd        (back_cmd),
        .cmd_pop    (cmd_pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .drain_done (drain_done),
        .kind       (kind),
        .character  (character),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

@@ rtl/sle_checker.sv @@
// Port-level checks of the scancode line editor, bound to the top level.
// Depends on sle_pkg and scancode_line_editor_top.
`timescale 1ns / 1ps

module sle_checker (
    input logic           clk,
    input logic           rst_n,
    input logic [7:0]     scancode,
    input logic           push,
    input logic           full,
    input sle_pkg::kind_t kind,
    input logic [6:0]     character,
    input logic           last,
    input logic           empty,
    input logic           pop
);
    import sle_pkg::*;

    // No result is offered in the cycle after reset is seen.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result offered during reset");

    // An accepted enter holds off the input while the line drains.
    a_enter_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && scancode == CODE_ENTER) |=> full)
        else $error("input open right after an enter transfer");

    // Results without a character carry zero in the character field.
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == KIND_BACK || kind == KIND_LINE_END || kind == KIND_DROPPED))
        |-> character == 7'd0)
        else $error("nonzero character on a result without one");

    // Only line characters are non-final; everything else closes its input.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == (kind != KIND_LINE_CHAR)))
        else $error("last flag does not match result kind");

    // A result that is not taken stays on the ports unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
        (!empty && $stable(kind) && $stable(character) && $stable(last)))
        else $error("waiting result changed before transfer");

endmodule

bind scancode_line_editor_top sle_checker u_sle_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the scancode line editor: a directed table, then random typing.
// Depends on rtl/sle_pkg.sv and rtl/scancode_line_editor_top.sv; results are predicted here.
`timescale 1ns / 1ps

module tb;

    import sle_pkg::*;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 380;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 200;
    localparam int DRAIN_CYCLES  = 20;

    // Lower-case character of each make code from 0 to 57.
    localparam logic [6:0] KEY_MAP [0:57] = '{
        7'h3F, 7'h3F, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h3F, 7'h3F, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h3F, 7'h3F,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h3F, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h3F, 7'h3F, 7'h3F, 7'h20
    };

    // How a directed row is checked.
    typedef enum int {
        CHECK_PREDICTED = 0,
        CHECK_SILENT    = 1,
        CHECK_TYPED     = 2
    } row_check_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] ch;
        logic       last;
    } editor_result_t;

    typedef struct {
        logic [7:0] code;
        int         reps;
        row_check_t check;
        kind_t      kind;
        logic [6:0] ch;
    } key_row_t;

    logic           clk;
    logic           rst_n;
    logic [7:0]     scancode;
    logic           push;
    logic           full;
    kind_t          kind;
    logic [6:0]     character;
    logic           last;
    logic           empty;
    logic           pop;

    // Predicted editor state.
    logic           caps_state;
    logic [6:0]     line_chars [0:LINE_DEPTH-1];
    int             line_len;

    editor_result_t pending_results [$];
    int             error_count;
    int             results_seen;
    int             idle_cycles;
    int             calm_left;

    scancode_line_editor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .scancode  (scancode),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .character (character),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Gap length for either side: mostly none or short, sometimes long, with calm stretches.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_result(input kind_t k, input logic [6:0] c, input logic l,
                                input bit keep);
        editor_result_t r;
        r.kind = k;
        r.ch   = c;
        r.last = l;
        if (keep)
            pending_results.push_back(r);
    endtask

    // Advances the predicted editor by one scancode and queues what it emits.
    task automatic editor_predict(input logic [7:0] code, input bit keep);
        logic [6:0] c;
        if (code == CODE_CAPS)
        begin
            caps_state = ~caps_state;
        end
        else if (code > CODE_TOP)
        begin
            c = 7'd0;
        end
        else if (code == CODE_BACKSPACE)
        begin
            if (line_len != 0)
            begin
                line_len--;
                queue_result(KIND_BACK, 7'd0, 1'b1, keep);
            end
        end
        else if (code == CODE_ENTER)
        begin
            for (int i = 0; i < line_len; i++)
                queue_result(KIND_LINE_CHAR, line_chars[i], 1'b0, keep);
            queue_result(KIND_LINE_END, 7'd0, 1'b1, keep);
            line_len = 0;
        end
        else
        begin
            c = KEY_MAP[code];
            if (caps_state && c >= 7'h61 && c <= 7'h7A)
                c = c - 7'd32;
            if (line_len >= LINE_DEPTH - 1)
            begin
                queue_result(KIND_DROPPED, 7'd0, 1'b1, keep);
            end
            else
            begin
                line_chars[line_len] = c;
                line_len++;
                queue_result(KIND_ECHO, c, 1'b1, keep);
            end
        end
    endtask

    // Offers one scancode and waits for its transfer, then predicts it.
    task automatic send_key(input logic [7:0] code, input bit keep);
        int g;
        g = idle_gap();
        repeat (g)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push     <= 1'b1;
        scancode <= code;
        do
            @(posedge clk);
        while (full);
        editor_predict(code, keep);
    endtask

    // A make code that types a character.
    function automatic logic [7:0] typing_code();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 57));
        while (c == CODE_BACKSPACE || c == CODE_ENTER || c == CODE_CAPS);
        return c;
    endfunction

    // One line: mostly characters, some corrections, caps toggles and noise, then enter.
    task automatic type_line(input int len_lo, input int len_hi, inout int count);
        int n;
        int r;
        n = $urandom_range(len_lo, len_hi);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                send_key(typing_code(), 1'b1);
                count++;
            end
            else if (r < 85)
            begin
                send_key(CODE_BACKSPACE, 1'b1);
                count++;
            end
            else if (r < 90)
            begin
                send_key(CODE_CAPS, 1'b1);
                count++;
            end
            else
            begin
                send_key(8'($urandom_range(58, 255)), 1'b1);
                count++;
            end
        end
        send_key(CODE_ENTER, 1'b1);
        count++;
    endtask

    // Directed rows: extremes of the code, every key class and the special cases.
    key_row_t key_rows [0:22] = '{
        '{8'h0E, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00},
        '{8'h1C, 1,  CHECK_TYPED,     KIND_LINE_END,  7'h00},
        '{8'hFF, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00},
        '{8'h3A, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00},
        '{8'h1E, 1,  CHECK_TYPED,     KIND_ECHO,      7'h41},
        '{8'h02, 1,  CHECK_TYPED,     KIND_ECHO,      7'h31},
        '{8'h3A, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00},
        '{8'h00, 1,  CHECK_TYPED,     KIND_ECHO,      7'h3F},
        '{8'h39, 1,  CHECK_TYPED,     KIND_ECHO,      7'h20},
        '{8'h3B, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00},
        '{8'h80, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00},
        '{8'h2C, 1,  CHECK_TYPED,     KIND_ECHO,      7'h7A},
        '{8'h0E, 1,  CHECK_TYPED,     KIND_BACK,      7'h00},
        '{8'h1C, 1,  CHECK_PREDICTED, KIND_ECHO,      7'h00},
        '{8'h10, 63, CHECK_PREDICTED, KIND_ECHO,      7'h00},
        '{8'h11, 1,  CHECK_TYPED,     KIND_DROPPED,   7'h00},
        '{8'h0E, 1,  CHECK_TYPED,     KIND_BACK,      7'h00},
        '{8'h19, 1,  CHECK_TYPED,     KIND_ECHO,      7'h70},
        '{8'h12, 1,  CHECK_TYPED,     KIND_DROPPED,   7'h00},
        '{8'h1C, 1,  CHECK_PREDICTED, KIND_ECHO,      7'h00},
        '{8'h7F, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00},
        '{8'hAA, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00},
        '{8'h55, 1,  CHECK_SILENT,    KIND_ECHO,      7'h00}
    };

    // Stimulus: reset, directed table, pause to drain, random typing, final drain.
    initial
    begin
        int count;
        int r;
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        scancode    = 8'h00;
        caps_state  = 1'b0;
        line_len    = 0;
        error_count = 0;
        calm_left   = 0;
        count       = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (key_rows[i])
        begin
            for (int j = 0; j < key_rows[i].reps; j++)
            begin
                send_key(key_rows[i].code, key_rows[i].check == CHECK_PREDICTED);
                if (key_rows[i].check == CHECK_TYPED)
                    queue_result(key_rows[i].kind, key_rows[i].ch, 1'b1, 1'b1);
            end
        end

        // Sender pause until every expected result has come.
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        while (count < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                type_line(0, 16, count);
            else if (r < 95)
                type_line(58, 72, count);
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    send_key(8'($urandom_range(58, 255)), 1'b1);
                    count++;
                end
            end
        end

        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("FAIL");
        end
        $finish;
    end

    // Receiver: random pop gaps and one long hold-off while the sender keeps pushing.
    initial
    begin
        int g;
        bit held;
        editor_result_t exp_r;
        held         = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                g    = HOLD_CYCLES;
            end
            else
            begin
                g = idle_gap();
            end
            repeat (g)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d character %0h last %0b",
                       kind, character, last);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (kind !== exp_r.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_r.kind, kind);
                    error_count++;
                end
                if (character !== exp_r.ch)
                begin
                    $error("character: expected %0h, actual %0h", exp_r.ch, character);
                    error_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last: expected %0b, actual %0b", exp_r.last, last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $error("no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
